>>> design/xhtml_char_class_tagger_top_defines.svh
// Assertion macros for the markup character class tagger.
// Included by the top level; depends on nothing else.
`ifndef XHTML_CHAR_CLASS_TAGGER_TOP_DEFINES_SVH
`define XHTML_CHAR_CLASS_TAGGER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define XCT_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("xct: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define XCT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("xct: next-cycle check failed");

`endif

>>> design/xct_pkg.sv
// Package for the markup character class tagger: class codes, opcodes and
// character constants. No dependencies.
`default_nettype none

package xct_pkg;

  typedef logic [2:0] char_class_t;

  localparam char_class_t CLS_NORMAL = 3'd0;
  localparam char_class_t CLS_TAG    = 3'd1;
  localparam char_class_t CLS_STRING = 3'd2;
  localparam char_class_t CLS_ATTR   = 3'd3;
  localparam char_class_t CLS_STYLE  = 3'd4;
  localparam char_class_t CLS_SCRIPT = 3'd5;
  localparam char_class_t CLS_ERROR  = 3'd6;
  localparam char_class_t CLS_NONE   = 3'd7;

  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_BLOCK = 1'b1;

  localparam logic [7:0] CHR_NONLATIN = 8'h00;
  localparam logic [7:0] CHR_SPACE    = 8'h20;
  localparam logic [7:0] CHR_QUOTE    = 8'h22;
  localparam logic [7:0] CHR_APOS     = 8'h27;
  localparam logic [7:0] CHR_SLASH    = 8'h2F;
  localparam logic [7:0] CHR_LT       = 8'h3C;
  localparam logic [7:0] CHR_EQ       = 8'h3D;
  localparam logic [7:0] CHR_GT       = 8'h3E;

  localparam logic [2:0] NAME_LEN_MAX = 3'd7;
  localparam logic [2:0] STYLE_LEN    = 3'd5;
  localparam logic [2:0] SCRIPT_LEN   = 3'd6;

  // Element 0 is the first letter of the word.
  localparam logic [4:0][7:0] WORD_STYLE  = {8'h65, 8'h6C, 8'h79, 8'h74, 8'h73};
  localparam logic [5:0][7:0] WORD_SCRIPT = {8'h74, 8'h70, 8'h69, 8'h72, 8'h63, 8'h73};

endpackage

`default_nettype wire

>>> design/xct_if.sv
// Valid/ready channel interfaces for the character input and the class output.
// Depends on xct_pkg.
`default_nettype none

interface xct_char_if
  import xct_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

interface xct_class_if
  import xct_pkg::*;
();
  logic        valid;
  logic        ready;
  char_class_t char_class;

  modport source (output valid, output char_class, input ready);
  modport sink   (input valid, input char_class, output ready);
endinterface

`default_nettype wire

>>> design/xhtml_char_class_tagger_top.sv
// Markup character class tagger, top level.
// Depends on xct_pkg, xct_if.sv and xhtml_char_class_tagger_top_defines.svh.
//
// Usage: characters and block-start markers arrive on the chars channel, one
// transfer per item. A character produces exactly one class transfer on the
// classes channel; a block start updates the tag state and produces nothing.
// All state is updated in the cycle an item is taken and the class lands in
// the output register, so a result is offered in the cycle after its transfer.
// Throughput is one item per cycle: the single output register is refilled
// in the same cycle it is drained, so chars.ready stays high while the
// receiver takes results. When the receiver stalls with a result pending,
// chars.ready drops and the tag state holds until the result is taken.
// Reset (rst, synchronous) clears all tag flags, the sticky error, the
// character position and the collected tag name, and empties the output.
// The sticky error set by a nested '<' clears only by reset.
`default_nettype none

`include "xhtml_char_class_tagger_top_defines.svh"

module xhtml_char_class_tagger_top
  import xct_pkg::*;
#(
  parameter int POSITION_BITS = 16,
  parameter int NAME_SLOTS    = 6
) (
  input  wire          clk,
  input  wire          rst,
  xct_char_if.sink     chars,
  xct_class_if.source  classes
);

  localparam int NameIdxBits = $clog2(NAME_SLOTS);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [NAME_SLOTS-1:0][7:0] name_t;

  logic        tag_open, tag_open_next;
  logic        closing_tag, closing_tag_next;
  logic        name_begun, name_begun_next;
  logic        name_finished, name_finished_next;
  logic        attr_begun, attr_begun_next;
  logic        attr_finished, attr_finished_next;
  logic        in_single_quote, in_single_quote_next;
  logic        in_double_quote, in_double_quote_next;
  logic        raw_text_mode, raw_text_mode_next;
  logic        error_latched, error_latched_next;
  char_class_t current_class, current_class_next;
  pos_t        char_position, char_position_next;
  pos_t        tag_start_position, tag_start_position_next;
  name_t       name_chars, name_chars_next;
  logic [2:0]  name_length, name_length_next;

  logic        out_valid;
  char_class_t out_class;

  logic        in_fire;
  logic        res_valid;
  char_class_t res_class;
  logic [7:0]  c;
  logic        quoted;
  logic        slash_after_lt;
  logic        is_style;
  logic        is_script;

  assign chars.ready        = !out_valid || classes.ready;
  assign in_fire            = chars.valid && chars.ready;
  assign classes.valid      = out_valid;
  assign classes.char_class = out_class;

  assign c      = chars.char_code;
  assign quoted = in_single_quote || in_double_quote;

  // The slash test compares against the opening '<' position plus one, unwrapped.
  assign slash_after_lt = ({1'b0, char_position} ==
                           ({1'b0, tag_start_position} + (POSITION_BITS + 1)'(1)));

  always_comb begin
    is_style  = (name_length == STYLE_LEN);
    is_script = (name_length == SCRIPT_LEN);
    for (int i = 0; i < 5; i++) begin
      if (name_chars[i] != WORD_STYLE[i]) is_style = 1'b0;
    end
    for (int i = 0; i < 6; i++) begin
      if (name_chars[i] != WORD_SCRIPT[i]) is_script = 1'b0;
    end
  end

  always_comb begin
    tag_open_next           = tag_open;
    closing_tag_next        = closing_tag;
    name_begun_next         = name_begun;
    name_finished_next      = name_finished;
    attr_begun_next         = attr_begun;
    attr_finished_next      = attr_finished;
    in_single_quote_next    = in_single_quote;
    in_double_quote_next    = in_double_quote;
    raw_text_mode_next      = raw_text_mode;
    error_latched_next      = error_latched;
    current_class_next      = current_class;
    char_position_next      = char_position;
    tag_start_position_next = tag_start_position;
    name_chars_next         = name_chars;
    name_length_next        = name_length;
    res_valid               = 1'b0;
    res_class               = current_class;

    if (chars.opcode == OP_BLOCK) begin
      if (!tag_open) begin
        closing_tag_next        = 1'b0;
        name_begun_next         = 1'b0;
        name_finished_next      = 1'b0;
        attr_begun_next         = 1'b0;
        attr_finished_next      = 1'b0;
        in_single_quote_next    = 1'b0;
        in_double_quote_next    = 1'b0;
        tag_start_position_next = '0;
      end else begin
        current_class_next = CLS_NORMAL;
      end
      char_position_next = '0;
    end else begin
      res_valid = 1'b1;
      if (char_position != '1) begin
        char_position_next = char_position + pos_t'(1);
      end

      if (error_latched || c == CHR_NONLATIN) begin
        res_class = current_class;
      end else if (tag_open) begin
        unique case (c)
          CHR_SLASH: begin
            if (!quoted) begin
              if (!name_begun && slash_after_lt) closing_tag_next = 1'b1;
              if (!closing_tag_next && attr_begun) begin
                attr_begun_next    = 1'b0;
                attr_finished_next = 1'b1;
              end
              current_class_next = CLS_TAG;
            end
            res_class = current_class_next;
          end
          CHR_SPACE: begin
            if (!quoted) begin
              if (!name_begun) begin
                current_class_next = CLS_NORMAL;
              end else if (attr_begun) begin
                attr_begun_next    = 1'b0;
                attr_finished_next = 1'b1;
                current_class_next = CLS_TAG;
              end else begin
                name_finished_next = 1'b1;
                current_class_next = CLS_NORMAL;
              end
            end
            res_class = current_class_next;
          end
          CHR_EQ: begin
            if (!quoted && attr_begun) begin
              attr_begun_next    = 1'b0;
              attr_finished_next = 1'b1;
              current_class_next = CLS_TAG;
            end
            res_class = current_class_next;
          end
          CHR_GT: begin
            res_class = CLS_NONE;
            if (!quoted) begin
              res_class = current_class;
              if (attr_begun || attr_finished) begin
                attr_begun_next    = 1'b0;
                attr_finished_next = 1'b0;
                current_class_next = CLS_NORMAL;
              end
              if (name_begun) begin
                name_finished_next = 1'b0;
                name_begun_next    = 1'b0;
              end
              tag_open_next = 1'b0;
            end
            if (!closing_tag) begin
              if (is_style) begin
                raw_text_mode_next = 1'b1;
                current_class_next = CLS_STYLE;
              end else if (is_script) begin
                raw_text_mode_next = 1'b1;
                current_class_next = CLS_SCRIPT;
              end
            end else begin
              closing_tag_next = 1'b0;
            end
            name_length_next = '0;
            name_chars_next  = '0;
          end
          CHR_APOS: begin
            if (!in_double_quote) begin
              in_single_quote_next = !in_single_quote;
              current_class_next   = in_single_quote ? CLS_TAG : CLS_STRING;
            end
            res_class = current_class_next;
          end
          CHR_QUOTE: begin
            if (!in_single_quote) begin
              if (in_double_quote) begin
                in_double_quote_next = 1'b0;
                current_class_next   = CLS_TAG;
              end else if (!raw_text_mode) begin
                in_double_quote_next = 1'b1;
                current_class_next   = CLS_STRING;
              end
            end
            res_class = current_class_next;
          end
          CHR_LT: begin
            if (!quoted) begin
              current_class_next = CLS_ERROR;
              error_latched_next = 1'b1;
            end
            res_class = current_class_next;
          end
          default: begin
            if (!quoted) begin
              if (!name_begun || !name_finished) begin
                // Collect the name; only the first slots are stored.
                if (!name_begun) begin
                  name_begun_next    = 1'b1;
                  current_class_next = CLS_TAG;
                end
                if ({1'b0, name_length} < 4'(NAME_SLOTS)) begin
                  name_chars_next[name_length[NameIdxBits-1:0]] = c;
                end
                if (name_length != NAME_LEN_MAX) begin
                  name_length_next = name_length + 3'd1;
                end
              end else if (attr_finished) begin
                current_class_next = CLS_TAG;
              end else if (!attr_begun) begin
                attr_begun_next    = 1'b1;
                attr_finished_next = 1'b0;
                current_class_next = CLS_ATTR;
              end
            end
            res_class = current_class_next;
          end
        endcase
      end else if (c == CHR_LT) begin
        tag_open_next           = 1'b1;
        tag_start_position_next = char_position;
        current_class_next      = CLS_TAG;
        raw_text_mode_next      = 1'b0;
        res_class               = CLS_TAG;
      end else if (raw_text_mode) begin
        res_class = current_class;
      end else begin
        res_class = CLS_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_open           <= 1'b0;
      closing_tag        <= 1'b0;
      name_begun         <= 1'b0;
      name_finished      <= 1'b0;
      attr_begun         <= 1'b0;
      attr_finished      <= 1'b0;
      in_single_quote    <= 1'b0;
      in_double_quote    <= 1'b0;
      raw_text_mode      <= 1'b0;
      error_latched      <= 1'b0;
      current_class      <= CLS_NORMAL;
      char_position      <= '0;
      tag_start_position <= '0;
      name_chars         <= '0;
      name_length        <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (in_fire) begin
        tag_open           <= tag_open_next;
        closing_tag        <= closing_tag_next;
        name_begun         <= name_begun_next;
        name_finished      <= name_finished_next;
        attr_begun         <= attr_begun_next;
        attr_finished      <= attr_finished_next;
        in_single_quote    <= in_single_quote_next;
        in_double_quote    <= in_double_quote_next;
        raw_text_mode      <= raw_text_mode_next;
        error_latched      <= error_latched_next;
        current_class      <= current_class_next;
        char_position      <= char_position_next;
        tag_start_position <= tag_start_position_next;
        name_chars         <= name_chars_next;
        name_length        <= name_length_next;
      end
      if (in_fire) begin
        out_valid <= res_valid;
      end else if (classes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_class <= res_class;
    end
  end

  // Every accepted character must show up as a result in the next cycle.
  `XCT_ASSERT_NEXT(a_char_gives_result, clk, rst,
                   in_fire && chars.opcode == OP_CHAR, out_valid)
  // The error latch is sticky.
  `XCT_ASSERT_NEXT(a_error_sticky, clk, rst, error_latched, error_latched)
  // The error class is only ever held together with the latched error.
  `XCT_ASSERT_NOW(a_error_class_latched, clk, rst,
                  current_class == CLS_ERROR, error_latched)

endmodule

`default_nettype wire

>>> tb/xhtml_char_class_tagger_top_test.sv
`timescale 1ns / 100ps
// Testbench for the markup character class tagger: directed and random character streams,
// a scoreboard class that predicts each class and checks it as it comes out.
// Depends on xct_pkg, xct_if.sv and xhtml_char_class_tagger_top.
import xct_pkg::*;

class class_scoreboard;
  localparam int POS_BITS = 16;

  bit tag_open, closing_tag, name_begun, name_finished, attr_begun, attr_finished;
  bit in_squote, in_dquote, raw_text, error_latched;
  char_class_t cur_cls;
  logic [POS_BITS-1:0] char_pos, tag_start;
  logic [5:0][7:0] name_buf;
  logic [2:0] name_len;
  char_class_t expected_q[$];
  int fail_count;

  function new();
    clear_tag();
    raw_text = 1'b0;
    error_latched = 1'b0;
    cur_cls = CLS_NORMAL;
    char_pos = '0;
    clear_name();
    fail_count = 0;
  endfunction

  function void clear_tag();
    tag_open = 1'b0;
    closing_tag = 1'b0;
    name_begun = 1'b0;
    name_finished = 1'b0;
    attr_begun = 1'b0;
    attr_finished = 1'b0;
    in_squote = 1'b0;
    in_dquote = 1'b0;
    tag_start = '0;
  endfunction

  function void clear_name();
    name_len = '0;
    name_buf = '0;
  endfunction

  function void add_name_char(logic [7:0] c);
    if (name_len < 6) name_buf[name_len] = c;
    if (name_len < NAME_LEN_MAX) name_len++;
  endfunction

  function bit name_matches(logic [5:0][7:0] word, logic [2:0] len);
    int i;
    if (name_len != len) return 1'b0;
    for (i = 0; i < len; i++) begin
      if (name_buf[i] != word[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void end_attr();
    attr_begun = 1'b0;
    attr_finished = 1'b1;
    cur_cls = CLS_TAG;
  endfunction

  // A '<' now would latch the sticky error.
  function bit lt_latches();
    return tag_open && !in_squote && !in_dquote && !error_latched;
  endfunction

  function void note(logic op, logic [7:0] c);
    logic [POS_BITS-1:0] pos;
    bit quoted;
    char_class_t cls;
    if (op == OP_BLOCK) begin
      if (!tag_open) clear_tag();
      else cur_cls = CLS_NORMAL;
      char_pos = '0;
      return;
    end
    pos = char_pos;
    if (char_pos != '1) char_pos++;
    quoted = in_squote || in_dquote;
    cls = cur_cls;
    if (error_latched || c == CHR_NONLATIN) begin
      cls = cur_cls;
    end else if (!tag_open) begin
      if (c == CHR_LT) begin
        tag_open = 1'b1;
        tag_start = pos;
        cur_cls = CLS_TAG;
        raw_text = 1'b0;
        cls = CLS_TAG;
      end else if (!raw_text) begin
        cls = CLS_NONE;
      end
    end else begin
      case (c)
        CHR_SLASH: begin
          if (!quoted) begin
            // The slash test must not wrap when the start position is saturated.
            if (!name_begun && {1'b0, pos} == {1'b0, tag_start} + 1) closing_tag = 1'b1;
            if (!closing_tag && attr_begun) end_attr();
            cur_cls = CLS_TAG;
          end
        end
        CHR_SPACE: begin
          if (!quoted) begin
            if (!name_begun) begin
              cur_cls = CLS_NORMAL;
            end else if (attr_begun) begin
              end_attr();
            end else begin
              name_finished = 1'b1;
              cur_cls = CLS_NORMAL;
            end
          end
        end
        CHR_EQ: begin
          if (!quoted && attr_begun) end_attr();
        end
        CHR_GT: begin
          cls = quoted ? CLS_NONE : cur_cls;
          if (!quoted) begin
            if (attr_begun || attr_finished) begin
              attr_begun = 1'b0;
              attr_finished = 1'b0;
              cur_cls = CLS_NORMAL;
            end
            if (name_begun) begin
              name_finished = 1'b0;
              name_begun = 1'b0;
            end
            tag_open = 1'b0;
          end
          // The name check runs even when the '>' is quoted.
          if (!closing_tag) begin
            if (name_matches(WORD_STYLE, STYLE_LEN)) begin
              raw_text = 1'b1;
              cur_cls = CLS_STYLE;
            end else if (name_matches(WORD_SCRIPT, SCRIPT_LEN)) begin
              raw_text = 1'b1;
              cur_cls = CLS_SCRIPT;
            end
          end else begin
            closing_tag = 1'b0;
          end
          clear_name();
        end
        CHR_APOS: begin
          if (!in_dquote) begin
            if (in_squote) begin
              in_squote = 1'b0;
              cur_cls = CLS_TAG;
            end else begin
              in_squote = 1'b1;
              cur_cls = CLS_STRING;
            end
          end
        end
        CHR_QUOTE: begin
          if (!in_squote) begin
            if (in_dquote) begin
              in_dquote = 1'b0;
              cur_cls = CLS_TAG;
            end else if (!raw_text) begin
              in_dquote = 1'b1;
              cur_cls = CLS_STRING;
            end
          end
        end
        CHR_LT: begin
          if (!quoted) begin
            cur_cls = CLS_ERROR;
            error_latched = 1'b1;
          end
        end
        default: begin
          if (!quoted) begin
            if (!name_begun) begin
              name_begun = 1'b1;
              cur_cls = CLS_TAG;
              add_name_char(c);
            end else if (name_finished) begin
              if (attr_finished) begin
                cur_cls = CLS_TAG;
              end else if (!attr_begun) begin
                attr_begun = 1'b1;
                attr_finished = 1'b0;
                cur_cls = CLS_ATTR;
              end
            end else begin
              add_name_char(c);
            end
          end
        end
      endcase
      if (c != CHR_GT) cls = cur_cls;
    end
    expected_q.push_back(cls);
  endfunction

  function void check(char_class_t got);
    char_class_t exp_cls;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("class %0d came out with no character pending", got);
      return;
    end
    exp_cls = expected_q.pop_front();
    if (got !== exp_cls) begin
      fail_count++;
      if (fail_count <= 10) $display("class mismatch: expected %0d, got %0d", exp_cls, got);
    end
  endfunction
endclass

module xhtml_char_class_tagger_top_test;
  import xct_pkg::*;

  localparam int LIMIT_NS = 2_000_000;

  logic clk = 1'b0;
  logic rst;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  bit keep_clean;
  class_scoreboard sb;

  xct_char_if chars_bus ();
  xct_class_if class_bus ();

  xhtml_char_class_tagger_top u_dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_bus),
    .classes(class_bus)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    class_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && class_bus.valid && class_bus.ready) sb.check(class_bus.char_class);
  end

  task automatic send_item(input logic op, input logic [7:0] ch);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      chars_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_bus.valid <= 1'b1;
    chars_bus.opcode <= op;
    chars_bus.char_code <= ch;
    @(posedge clk);
    while (!(chars_bus.valid && chars_bus.ready)) @(posedge clk);
    sb.note(op, ch);
    items_sent++;
  endtask

  // Until the error phase, a '<' that would latch the sticky error is swapped for a letter.
  task automatic put_char(input logic [7:0] c);
    if (keep_clean && c == CHR_LT && sb.lt_latches()) c = 8'h61;
    send_item(OP_CHAR, c);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] body_char();
    case ($urandom_range(9))
      0: return CHR_GT;
      1: return CHR_LT;
      2: return CHR_SLASH;
      3: return CHR_SPACE;
      4: return CHR_EQ;
      5: return $urandom_range(1) ? CHR_APOS : CHR_QUOTE;
      6: return CHR_NONLATIN;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // One tag with random name, attributes and quoted values, then some text.
  // A broken tag is cut short or split by a block start.
  task automatic emit_markup(input bit broken);
    logic [8:0] seq[$];
    string nm;
    int len, cut, i;
    logic [7:0] q;
    seq.push_back({OP_CHAR, CHR_LT});
    if ($urandom_range(3) == 0) seq.push_back({OP_CHAR, CHR_SLASH});
    case ($urandom_range(5))
      0: nm = "style";
      1: nm = "script";
      2: nm = "scripts";
      3: nm = "styl";
      default: nm = "";
    endcase
    if (nm.len() == 0) begin
      len = $urandom_range(1, 9);
      repeat (len) seq.push_back({OP_CHAR, 8'($urandom_range(8'h61, 8'h7A))});
    end else begin
      for (i = 0; i < nm.len(); i++) seq.push_back({OP_CHAR, nm[i]});
    end
    repeat ($urandom_range(2)) begin
      seq.push_back({OP_CHAR, CHR_SPACE});
      len = $urandom_range(1, 4);
      repeat (len) seq.push_back({OP_CHAR, 8'($urandom_range(8'h61, 8'h7A))});
      if ($urandom_range(2) != 0) begin
        seq.push_back({OP_CHAR, CHR_EQ});
        q = $urandom_range(1) ? CHR_APOS : CHR_QUOTE;
        seq.push_back({OP_CHAR, q});
        len = $urandom_range(5);
        repeat (len) seq.push_back({OP_CHAR, body_char()});
        seq.push_back({OP_CHAR, q});
      end
    end
    if ($urandom_range(4) == 0) begin
      seq.push_back({OP_CHAR, CHR_SPACE});
      seq.push_back({OP_CHAR, CHR_SLASH});
    end
    seq.push_back({OP_CHAR, CHR_GT});
    if (broken) begin
      cut = $urandom_range(seq.size() - 1);
      if ($urandom_range(1)) begin
        while (seq.size() > cut) void'(seq.pop_back());
      end else begin
        seq.insert(cut, {OP_BLOCK, 8'($urandom_range(255))});
      end
    end
    len = $urandom_range(6);
    repeat (len) seq.push_back({OP_CHAR, body_char()});
    for (i = 0; i < seq.size(); i++) begin
      if (seq[i][8] == OP_BLOCK) send_item(OP_BLOCK, seq[i][7:0]);
      else put_char(seq[i][7:0]);
    end
  endtask

  task automatic run_random(input int target);
    int r;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        emit_markup(1'b0);
      end else if (r < 85) begin
        emit_markup(1'b1);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(9) == 0) send_item(OP_BLOCK, 8'($urandom_range(255)));
          else put_char(8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Closes whatever tag is open so the next '<' starts a fresh one.
  task automatic close_tag();
    while (sb.tag_open) begin
      if (sb.in_squote) put_char(CHR_APOS);
      else if (sb.in_dquote) put_char(CHR_QUOTE);
      else put_char(CHR_GT);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    chars_bus.valid = 1'b0;
    chars_bus.opcode = OP_CHAR;
    chars_bus.char_code = CHR_NONLATIN;
    keep_clean = 1'b1;
    items_sent = 0;
    send_idle_pct = 33;
    recv_idle_pct = 67;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Non-Latin and top-of-range characters outside a tag, a closing tag,
    // a quoted '>' after a style name, an ignored double quote in raw text,
    // and a block start while a tag is open.
    put_char(CHR_NONLATIN);
    put_char(8'hFF);
    send_text("</p>");
    send_item(OP_BLOCK, 8'hFF);
    send_text("<style '>");
    send_text("'\">x");
    send_text("<b");
    send_item(OP_BLOCK, CHR_NONLATIN);
    send_text(">");

    run_random(530);
    send_idle_pct = 67;
    recv_idle_pct = 33;
    run_random(1070);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(1600);

    close_tag();
    send_text("</p></b>");
    send_item(OP_BLOCK, CHR_NONLATIN);

    // Nested '<' latches the error for the rest of the run.
    keep_clean = 1'b0;
    close_tag();
    send_text("<a<");
    repeat (40) begin
      if ($urandom_range(4) == 0) send_item(OP_BLOCK, 8'($urandom_range(255)));
      else send_item(OP_CHAR, 8'($urandom_range(255)));
    end

    @(negedge clk);
    chars_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/xct_pkg.sv
design/xct_if.sv
design/xhtml_char_class_tagger_top.sv
tb/xhtml_char_class_tagger_top_test.sv
